// ===== sv/hsv_pkg.sv =====
// Shared types and constants for the HSV to RGB color converter.
`default_nettype none
package hsv_pkg;

    // Pipeline depth from input register to output register.
    localparam int NUM_STAGES = 8;

    typedef logic [NUM_STAGES-1:0] stage_vec_t;

    // Hue wrap: offset makes any 16-bit signed hue positive and keeps it a
    // multiple of 360 away; the reciprocal gives the exact quotient by 360.
    localparam int HUE_W = 17;
    localparam logic [HUE_W-1:0] HUE_OFFSET = 17'd33120;
    localparam logic [HUE_W-1:0] HUE_RECIP = 17'd93207;
    localparam int HUE_SHIFT = 25;
    localparam logic [HUE_W-1:0] DEG_FULL = 17'd360;

    // Sector boundaries in degrees.
    localparam logic [8:0] DEG_60 = 9'd60;
    localparam logic [8:0] DEG_120 = 9'd120;
    localparam logic [8:0] DEG_180 = 9'd180;
    localparam logic [8:0] DEG_240 = 9'd240;
    localparam logic [8:0] DEG_300 = 9'd300;
    localparam logic [5:0] SECTOR_SPAN = 6'd60;

    // Exact division by 60 for scaled channel values below 2**14.
    localparam int SCALED_W = 14;
    localparam logic [18:0] CHAN_RECIP = 19'd279621;
    localparam int CHAN_SHIFT = 24;

    typedef enum logic [2:0] {
        SECT_RED_YELLOW  = 3'd0,
        SECT_YELLOW_GRN  = 3'd1,
        SECT_GRN_CYAN    = 3'd2,
        SECT_CYAN_BLUE   = 3'd3,
        SECT_BLUE_MAG    = 3'd4,
        SECT_MAG_RED     = 3'd5
    } sector_t;

    typedef struct packed {
        sector_t    sector;
        logic [5:0] rem;
    } hue_ctl_t;

    // Channel term order: full value, p, q and t.
    localparam int TERM_V = 0;
    localparam int TERM_P = 1;
    localparam int TERM_Q = 2;
    localparam int TERM_T = 3;
    localparam int NUM_TERMS = 4;

endpackage
`default_nettype wire

// ===== sv/hsv_to_rgb_color.sv =====
// Top level of the HSV to RGB color converter with stream ports.
//
// The converter takes one HSV word per clock and returns the matching RGB
// word through an eight-stage pipeline: input register, hue quotient by
// 360, hue remainder, sector split, channel terms, value product, byte
// scaling, and division by 60 with routing into the output register.
// Each stage advances whenever the stage after it is empty or moving, so
// bubbles close up and input is taken while a finished word waits at the
// output. Throughput is one word per clock while the output side takes
// words.
`default_nettype none
module hsv_to_rgb_color #(
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // hue_degrees, saturation, brightness, alpha_in, zero fill.
    input  wire logic [((2*FRACTION_BITS+26+7)/8)*8-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // red, green, blue, alpha_out.
    output logic [31:0]              m_axis_tdata
);

    localparam int SW = FRACTION_BITS + 1;
    localparam int NS = hsv_pkg::NUM_STAGES;

    hsv_pkg::stage_vec_t valid_reg, valid_next, en;
    logic [7:0]          alpha_reg [NS];
    hsv_pkg::hue_ctl_t   ctl;
    logic [SW-1:0]       sat_mid, val_mid;
    logic [7:0]          red, green, blue;

    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || m_axis_tready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next[0] = en[0] ? s_axis_tvalid : valid_reg[0];
        for (int i = 1; i < NS; i++)
        begin
            valid_next[i] = en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            alpha_reg[0] <= s_axis_tdata[2*FRACTION_BITS+18 +: 8];
        end
        for (int i = 1; i < NS; i++)
        begin
            if (en[i])
            begin
                alpha_reg[i] <= alpha_reg[i-1];
            end
        end
    end

    hsv_hue_unit #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_hue (
        .clk         (clk),
        .en          (en[3:0]),
        .hue_degrees (s_axis_tdata[15:0]),
        .saturation  (s_axis_tdata[16 +: SW]),
        .brightness  (s_axis_tdata[16+SW +: SW]),
        .ctl         (ctl),
        .sat_out     (sat_mid),
        .val_out     (val_mid)
    );

    hsv_chan_unit #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_chan (
        .clk    (clk),
        .en     (en[7:4]),
        .ctl    (ctl),
        .sat_in (sat_mid),
        .val_in (val_mid),
        .red    (red),
        .green  (green),
        .blue   (blue)
    );

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = valid_reg[NS-1];
    assign m_axis_tdata = {alpha_reg[NS-1], blue, green, red};

endmodule
`default_nettype wire

// ===== sv/hsv_hue_unit.sv =====
// Input register, hue wrap modulo 360, and sector split with clamped S and V.
`default_nettype none
module hsv_hue_unit #(
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                     clk,
    input  wire logic [3:0]               en,
    input  wire logic [15:0]              hue_degrees,
    input  wire logic [FRACTION_BITS:0]   saturation,
    input  wire logic [FRACTION_BITS:0]   brightness,
    output hsv_pkg::hue_ctl_t             ctl,
    output logic [FRACTION_BITS:0]        sat_out,
    output logic [FRACTION_BITS:0]        val_out
);

    localparam int SW = FRACTION_BITS + 1;
    localparam logic [SW-1:0] ONE = SW'(1 << FRACTION_BITS);
    localparam int PW = 2 * hsv_pkg::HUE_W;

    logic [hsv_pkg::HUE_W-1:0] u1_reg, u2_reg;
    logic [SW-1:0]             s1_reg, s2_reg, s3_reg, s4_reg;
    logic [SW-1:0]             v1_reg, v2_reg, v3_reg, v4_reg;
    logic [7:0]                q2_reg;
    logic [8:0]                h3_reg;
    hsv_pkg::hue_ctl_t         ctl4_reg;

    logic [hsv_pkg::HUE_W-1:0] u1_next;
    logic [PW-1:0]             quot_prod;
    logic [hsv_pkg::HUE_W-1:0] rem_full;
    hsv_pkg::hue_ctl_t         ctl4_next;
    logic [8:0]                base;

    assign u1_next = {hue_degrees[15], hue_degrees} + hsv_pkg::HUE_OFFSET;
    assign quot_prod = PW'(u1_reg) * PW'(hsv_pkg::HUE_RECIP);
    assign rem_full = u2_reg - hsv_pkg::HUE_W'(q2_reg) * hsv_pkg::DEG_FULL;

    always_comb
    begin
        if (h3_reg >= hsv_pkg::DEG_300)
        begin
            ctl4_next.sector = hsv_pkg::SECT_MAG_RED;
            base = hsv_pkg::DEG_300;
        end
        else if (h3_reg >= hsv_pkg::DEG_240)
        begin
            ctl4_next.sector = hsv_pkg::SECT_BLUE_MAG;
            base = hsv_pkg::DEG_240;
        end
        else if (h3_reg >= hsv_pkg::DEG_180)
        begin
            ctl4_next.sector = hsv_pkg::SECT_CYAN_BLUE;
            base = hsv_pkg::DEG_180;
        end
        else if (h3_reg >= hsv_pkg::DEG_120)
        begin
            ctl4_next.sector = hsv_pkg::SECT_GRN_CYAN;
            base = hsv_pkg::DEG_120;
        end
        else if (h3_reg >= hsv_pkg::DEG_60)
        begin
            ctl4_next.sector = hsv_pkg::SECT_YELLOW_GRN;
            base = hsv_pkg::DEG_60;
        end
        else
        begin
            ctl4_next.sector = hsv_pkg::SECT_RED_YELLOW;
            base = 9'd0;
        end
        ctl4_next.rem = 6'(h3_reg - base);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            u1_reg <= u1_next;
            s1_reg <= (saturation > ONE) ? ONE : saturation;
            v1_reg <= (brightness > ONE) ? ONE : brightness;
        end
        if (en[1])
        begin
            u2_reg <= u1_reg;
            q2_reg <= quot_prod[hsv_pkg::HUE_SHIFT +: 8];
            s2_reg <= s1_reg;
            v2_reg <= v1_reg;
        end
        if (en[2])
        begin
            h3_reg <= rem_full[8:0];
            s3_reg <= s2_reg;
            v3_reg <= v2_reg;
        end
        if (en[3])
        begin
            ctl4_reg <= ctl4_next;
            s4_reg <= s3_reg;
            v4_reg <= v3_reg;
        end
    end

    assign ctl = ctl4_reg;
    assign sat_out = s4_reg;
    assign val_out = v4_reg;

endmodule
`default_nettype wire

// ===== sv/hsv_chan_unit.sv =====
// Channel terms, value product, byte scaling, division by 60 and sector routing to RGB.
`default_nettype none
module hsv_chan_unit #(
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                   clk,
    input  wire logic [3:0]             en,
    input  wire hsv_pkg::hue_ctl_t      ctl,
    input  wire logic [FRACTION_BITS:0] sat_in,
    input  wire logic [FRACTION_BITS:0] val_in,
    output logic [7:0]                  red,
    output logic [7:0]                  green,
    output logic [7:0]                  blue
);

    localparam int SW = FRACTION_BITS + 1;
    localparam int FW = FRACTION_BITS + 6;
    localparam int PW = SW + FW;
    localparam int XW = PW + 8;
    localparam int DW = hsv_pkg::SCALED_W + 19;
    localparam logic [FW-1:0] ONE60 = FW'(60 * (1 << FRACTION_BITS));

    logic [FW-1:0]                fac_reg  [hsv_pkg::NUM_TERMS];
    logic [PW-1:0]                prod_reg [hsv_pkg::NUM_TERMS];
    logic [hsv_pkg::SCALED_W-1:0] w_reg    [hsv_pkg::NUM_TERMS];
    logic [SW-1:0]                v5_reg;
    hsv_pkg::sector_t             sec5_reg, sec6_reg, sec7_reg;
    logic [7:0]                   red_reg, green_reg, blue_reg;

    logic [FW-1:0]                fac_next  [hsv_pkg::NUM_TERMS];
    logic [XW-1:0]                scaled    [hsv_pkg::NUM_TERMS];
    logic [DW-1:0]                div_prod  [hsv_pkg::NUM_TERMS];
    logic [7:0]                   chan      [hsv_pkg::NUM_TERMS];
    logic [7:0]                   red_next, green_next, blue_next;

    always_comb
    begin
        fac_next[hsv_pkg::TERM_V] = ONE60;
        fac_next[hsv_pkg::TERM_P] = ONE60 - FW'(sat_in) * FW'(hsv_pkg::SECTOR_SPAN);
        fac_next[hsv_pkg::TERM_Q] = ONE60 - FW'(sat_in) * FW'(ctl.rem);
        fac_next[hsv_pkg::TERM_T] = ONE60
            - FW'(sat_in) * FW'(hsv_pkg::SECTOR_SPAN - ctl.rem);
    end

    always_comb
    begin
        for (int i = 0; i < hsv_pkg::NUM_TERMS; i++)
        begin
            scaled[i] = {prod_reg[i], 8'd0} - XW'(prod_reg[i]);
            div_prod[i] = DW'(w_reg[i]) * DW'(hsv_pkg::CHAN_RECIP);
            chan[i] = div_prod[i][hsv_pkg::CHAN_SHIFT +: 8];
        end
    end

    always_comb
    begin
        unique case (sec7_reg)
            hsv_pkg::SECT_YELLOW_GRN:
            begin
                red_next = chan[hsv_pkg::TERM_Q];
                green_next = chan[hsv_pkg::TERM_V];
                blue_next = chan[hsv_pkg::TERM_P];
            end
            hsv_pkg::SECT_GRN_CYAN:
            begin
                red_next = chan[hsv_pkg::TERM_P];
                green_next = chan[hsv_pkg::TERM_V];
                blue_next = chan[hsv_pkg::TERM_T];
            end
            hsv_pkg::SECT_CYAN_BLUE:
            begin
                red_next = chan[hsv_pkg::TERM_P];
                green_next = chan[hsv_pkg::TERM_Q];
                blue_next = chan[hsv_pkg::TERM_V];
            end
            hsv_pkg::SECT_BLUE_MAG:
            begin
                red_next = chan[hsv_pkg::TERM_T];
                green_next = chan[hsv_pkg::TERM_P];
                blue_next = chan[hsv_pkg::TERM_V];
            end
            hsv_pkg::SECT_MAG_RED:
            begin
                red_next = chan[hsv_pkg::TERM_V];
                green_next = chan[hsv_pkg::TERM_P];
                blue_next = chan[hsv_pkg::TERM_Q];
            end
            default:
            begin
                red_next = chan[hsv_pkg::TERM_V];
                green_next = chan[hsv_pkg::TERM_T];
                blue_next = chan[hsv_pkg::TERM_P];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < hsv_pkg::NUM_TERMS; i++)
            begin
                fac_reg[i] <= fac_next[i];
            end
            v5_reg <= val_in;
            sec5_reg <= ctl.sector;
        end
        if (en[1])
        begin
            for (int i = 0; i < hsv_pkg::NUM_TERMS; i++)
            begin
                prod_reg[i] <= PW'(v5_reg) * PW'(fac_reg[i]);
            end
            sec6_reg <= sec5_reg;
        end
        if (en[2])
        begin
            for (int i = 0; i < hsv_pkg::NUM_TERMS; i++)
            begin
                w_reg[i] <= scaled[i][2*FRACTION_BITS +: hsv_pkg::SCALED_W];
            end
            sec7_reg <= sec6_reg;
        end
        if (en[3])
        begin
            red_reg <= red_next;
            green_reg <= green_next;
            blue_reg <= blue_next;
        end
    end

    assign red = red_reg;
    assign green = green_reg;
    assign blue = blue_reg;

endmodule
`default_nettype wire

// ===== sv/hsv_checker.sv =====
// Port-level checks for the HSV to RGB color converter and their binding.
`default_nettype none
module hsv_checker #(
    parameter int FRACTION_BITS = 8
) (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_axis_tvalid,
    input wire logic                s_axis_tready,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [31:0]         m_axis_tdata
);

    localparam logic [4:0] DEPTH = 5'(hsv_pkg::NUM_STAGES);

    logic [4:0] count_reg, count_next;
    logic       in_acc, out_acc;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        count_next = count_reg;
        if (in_acc && !out_acc)
        begin
            count_next = count_reg + 5'd1;
        end
        else if (out_acc && !in_acc)
        begin
            count_next = count_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled output word changed or vanished.");

    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("Input stalled while the output side was ready.");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH)
        else $error("More words in flight than pipeline stages.");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> count_reg != 5'd0)
        else $error("Output word shown with no word in flight.");

endmodule

bind hsv_to_rgb_color hsv_checker #(
    .FRACTION_BITS(FRACTION_BITS)
) u_hsv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
